/* rtl/core/rrps_pkg.sv */
package rrps_pkg;

    // Slot table size and derived index width
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    // Fixed field widths
    localparam int SEG_W     = 16;
    localparam int TICK_W    = 7;
    localparam int SEG_SHIFT = 12;

    localparam logic [SEG_W-1:0]  STACK_INIT    = 16'hFF00;
    localparam logic [TICK_W-1:0] QUANTUM_RESET = 7'd100;
    localparam logic [TICK_W-1:0] TICK_RESET    = 7'd95;

    typedef logic [SLOT_W-1:0]    slot_idx_t;
    typedef logic [NUM_SLOTS-1:0] slot_vec_t;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_FIND_FREE = 3'd1,
        CMD_ACTIVATE  = 3'd2,
        CMD_KILL      = 3'd3,
        CMD_TERMINATE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_NO_RUN  = 2'd2
    } status_t;

    // Search result
    typedef struct packed {
        logic      found;
        slot_idx_t idx;
    } pick_t;

    // Requests to the saved stack pointer store
    typedef struct packed {
        logic             rd_en;
        slot_idx_t        rd_addr;
        logic             wr_en;
        slot_idx_t        wr_addr;
        logic [SEG_W-1:0] wr_data;
        logic             clr_en;
        slot_idx_t        clr_addr;
    } stk_req_t;

    // First active slot at or after base, wrapping around the table
    function automatic pick_t rr_pick(slot_vec_t act, slot_idx_t base);
        pick_t             p;
        logic [SLOT_W:0]   c;
        p = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            c = {1'b0, base} + (SLOT_W+1)'(i);
            if (c >= (SLOT_W+1)'(NUM_SLOTS))
            begin
                c = c - (SLOT_W+1)'(NUM_SLOTS);
            end
            if (!p.found && act[c[SLOT_W-1:0]])
            begin
                p.found = 1'b1;
                p.idx   = c[SLOT_W-1:0];
            end
        end
        return p;
    endfunction

    // Lowest inactive slot
    function automatic pick_t lowest_free(slot_vec_t act);
        pick_t p;
        p = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!p.found && !act[i])
            begin
                p.found = 1'b1;
                p.idx   = SLOT_W'(i);
            end
        end
        return p;
    endfunction

    // Segment of a slot: (slot + 2) * 0x1000, low 16 bits
    function automatic logic [SEG_W-1:0] seg_of(slot_idx_t s);
        logic [SEG_W-1:0] t;
        t = SEG_W'(s) + SEG_W'(2);
        return t << SEG_SHIFT;
    endfunction

endpackage

/* rtl/core/rrps_stack_store.sv */
// Saved stack pointer table: synchronous RAM with one read and one write port, with per-entry
// valid bits; an entry not written since reset or cleared reads as
// the initial stack pointer.
module rrps_stack_store
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrps_pkg::stk_req_t            req,
    output logic [rrps_pkg::SEG_W-1:0]    rd_data
);

    logic [rrps_pkg::SEG_W-1:0]     mem [rrps_pkg::NUM_SLOTS];
    logic [rrps_pkg::SEG_W-1:0]     rd_q_reg;
    logic                           rd_vld_reg;
    rrps_pkg::slot_vec_t            valid_reg;

    // RAM write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    // Valid bits: set on write, dropped on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.clr_en)
            begin
                valid_reg[req.clr_addr] <= 1'b0;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : rrps_pkg::STACK_INIT;

endmodule

/* rtl/core/round_robin_process_scheduler_unit.sv */
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tuser: cmd; s_tdata: cur_segment, cur_sp, slot
// m_*       out        m_tvalid / m_tready  m_tdata: result fields, see port list
// cfg_*     in         cfg_valid/cfg_ready  cfg_data: quantum_limit
//
// Each item passes through S_IN and S_EXEC: the accept in S_IN reads the saved stack
// pointer RAM at the round-robin candidate, and S_EXEC updates state and loads the
// output register. S_EXEC uses the registered RAM read data.
// Reset is asynchronous; valid bits restore the table at once, no
// clearing pass. A stalled output holds the update cycle until the
// output register frees; an input is taken while a result waits.
module round_robin_process_scheduler_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // cmd[2:0]
    input  logic [7:0]  s_tuser,
    // cur_segment[15:0], cur_sp[31:16], slot[34:32], zero pad
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // resume_segment[15:0], resume_sp[31:16], switched[32], free_slot[35:33],
    // load_segment[51:36], running[52], running_slot[55:53], status[57:56], zero pad
    output logic [63:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [6:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    typedef enum logic [1:0] {
        S_IN   = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                                 state_reg, state_next;

    // Scheduler state
    rrps_pkg::slot_vec_t                    active_reg, active_next;
    rrps_pkg::slot_idx_t                    cur_reg, cur_next;
    logic                                   idle_reg, idle_next;
    logic [rrps_pkg::TICK_W-1:0]            tick_reg, tick_next;
    logic [rrps_pkg::TICK_W-1:0]            quantum_reg;

    // Latched item and search result
    logic [2:0]                             cmd_reg;
    logic [rrps_pkg::SEG_W-1:0]             cseg_reg;
    logic [rrps_pkg::SEG_W-1:0]             csp_reg;
    logic [2:0]                             slot_reg;
    rrps_pkg::pick_t                        pick_reg;

    // Output register
    logic                                   m_tvalid_reg;
    logic [63:0]                            m_tdata_reg;
    logic [63:0]                            result;

    rrps_pkg::stk_req_t                     stk_req;
    logic [rrps_pkg::SEG_W-1:0]             stk_rd_data;
    rrps_pkg::slot_idx_t                    base;
    rrps_pkg::pick_t                        pick;
    rrps_pkg::pick_t                        free_pick;
    rrps_pkg::slot_idx_t                    slot_idx;
    logic                                   slot_ok;
    logic                                   s_fire;
    logic                                   out_free;
    logic                                   commit;

    // Result fields
    logic [rrps_pkg::SEG_W-1:0]             rseg;
    logic [rrps_pkg::SEG_W-1:0]             rsp;
    logic                                   sw;
    logic [2:0]                             fslot;
    logic [rrps_pkg::SEG_W-1:0]             lseg;
    rrps_pkg::status_t                      status;

    assign s_tready  = (state_reg == S_IN);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign commit    = (state_reg == S_EXEC) && out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Round-robin candidate, searched at accept time
    always_comb
    begin
        if (idle_reg)
        begin
            base = '0;
        end
        else if (cur_reg == rrps_pkg::slot_idx_t'(rrps_pkg::NUM_SLOTS - 1))
        begin
            base = '0;
        end
        else
        begin
            base = cur_reg + 1'b1;
        end
        pick      = rrps_pkg::rr_pick(active_reg, base);
        free_pick = rrps_pkg::lowest_free(active_reg);
    end

    assign slot_idx = rrps_pkg::slot_idx_t'(slot_reg);
    assign slot_ok  = (int'(slot_reg) < rrps_pkg::NUM_SLOTS);

    // Execute: state update and result
    always_comb
    begin
        active_next = active_reg;
        cur_next    = cur_reg;
        idle_next   = idle_reg;
        tick_next   = tick_reg;
        rseg        = '0;
        rsp         = '0;
        sw          = 1'b0;
        fslot       = '0;
        lseg        = '0;
        status      = rrps_pkg::ST_OK;
        stk_req          = '0;
        stk_req.rd_en    = s_fire;
        stk_req.rd_addr  = pick.idx;
        stk_req.wr_addr  = cur_reg;
        stk_req.wr_data  = csp_reg;
        stk_req.clr_addr = cur_reg;

        case (cmd_reg)
            rrps_pkg::CMD_TICK:
            begin
                rseg = cseg_reg;
                rsp  = csp_reg;
                if (tick_reg >= quantum_reg)
                begin
                    tick_next = '0;
                    if (pick_reg.found && (idle_reg || pick_reg.idx != cur_reg))
                    begin
                        stk_req.wr_en = commit && !idle_reg;
                        cur_next      = pick_reg.idx;
                        idle_next     = 1'b0;
                        rseg          = rrps_pkg::seg_of(pick_reg.idx);
                        rsp           = stk_rd_data;
                        sw            = 1'b1;
                    end
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            rrps_pkg::CMD_FIND_FREE:
            begin
                if (free_pick.found)
                begin
                    fslot = 3'(free_pick.idx);
                    lseg  = rrps_pkg::seg_of(free_pick.idx);
                end
                else
                begin
                    status = rrps_pkg::ST_NO_FREE;
                end
            end
            rrps_pkg::CMD_ACTIVATE:
            begin
                if (slot_ok)
                begin
                    active_next[slot_idx] = 1'b1;
                end
            end
            rrps_pkg::CMD_KILL:
            begin
                if (slot_ok)
                begin
                    active_next[slot_idx] = 1'b0;
                    stk_req.clr_en        = commit;
                    stk_req.clr_addr      = slot_idx;
                end
            end
            rrps_pkg::CMD_TERMINATE:
            begin
                if (idle_reg)
                begin
                    status = rrps_pkg::ST_NO_RUN;
                end
                else
                begin
                    active_next[cur_reg] = 1'b0;
                    stk_req.clr_en       = commit;
                end
            end
            default:
            begin
            end
        endcase

        result = {6'd0, status, (idle_next ? 3'd0 : 3'(cur_next)), !idle_next,
                  lseg, fslot, sw, rsp, rseg};
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IN:
            begin
                if (s_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IN;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // Control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IN;
            active_reg   <= '0;
            cur_reg      <= '0;
            idle_reg     <= 1'b1;
            tick_reg     <= rrps_pkg::TICK_RESET;
            quantum_reg  <= rrps_pkg::QUANTUM_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                quantum_reg <= cfg_data;
            end
            if (commit)
            begin
                active_reg <= active_next;
                cur_reg    <= cur_next;
                idle_reg   <= idle_next;
                tick_reg   <= tick_next;
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg  <= s_tuser[2:0];
            cseg_reg <= s_tdata[15:0];
            csp_reg  <= s_tdata[31:16];
            slot_reg <= s_tdata[34:32];
            pick_reg <= pick;
        end
        if (commit)
        begin
            m_tdata_reg <= result;
        end
    end

    rrps_stack_store u_stack
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (stk_req),
        .rd_data (stk_rd_data)
    );

endmodule

/* rtl/core/rrps_checker.sv */
module rrps_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready
);

    // A held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during update cycle");

    // Idle reports slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[52] |-> m_tdata[55:53] == 3'd0)
        else $error("idle result with nonzero slot");

    // A switch lands on a running process at its own segment
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[52] && m_tdata[11:0] == 12'd0
            && m_tdata[15:12] == {1'b0, m_tdata[55:53]} + 4'd2)
        else $error("switch result inconsistent");

endmodule

bind round_robin_process_scheduler_unit rrps_checker u_rrps_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    // Command codes past terminate are unused and must leave the state alone
    localparam logic [2:0] CMD_SPARE_LO = 3'(rrps_pkg::CMD_TERMINATE + 1);
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // One command item as the scheduler sees it
    typedef struct packed {
        logic [2:0]                 cmd;
        rrps_pkg::slot_idx_t        slot;
        logic [rrps_pkg::SEG_W-1:0] cur_sp;
        logic [rrps_pkg::SEG_W-1:0] cur_segment;
    } sched_cmd_t;

    // Result item, laid out as m_tdata from bit 63 down
    typedef struct packed {
        logic [5:0]                 pad;
        logic [1:0]                 status;
        rrps_pkg::slot_idx_t        running_slot;
        logic                       running;
        logic [rrps_pkg::SEG_W-1:0] load_segment;
        rrps_pkg::slot_idx_t        free_slot;
        logic                       switched;
        logic [rrps_pkg::SEG_W-1:0] resume_sp;
        logic [rrps_pkg::SEG_W-1:0] resume_segment;
    } dispatch_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic [7:0]  s_tuser = '0;    // cmd
    logic [39:0] s_tdata = '0;    // cur_segment, cur_sp, slot, zero pad
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] m_tdata;         // resume_segment .. status, see dispatch_t
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [6:0]  cfg_data = '0;   // quantum_limit
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    // Scheduler state mirror
    rrps_pkg::slot_vec_t          proc_live;
    logic [rrps_pkg::SEG_W-1:0]   proc_saved_sp [rrps_pkg::NUM_SLOTS];
    rrps_pkg::slot_idx_t          proc_cur;
    logic                         proc_idle;
    logic [rrps_pkg::TICK_W-1:0]  tick_cnt;
    logic [rrps_pkg::TICK_W-1:0]  quantum;

    sched_cmd_t pending_cmds [$];
    dispatch_t  dispatch_due [$];
    sched_cmd_t bus_cmd;
    sched_cmd_t drv_next;
    dispatch_t  mon_want;
    dispatch_t  mon_got;

    int burst_left = 0;
    int gap_left = 0;
    int n_accepted = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int rdy_mode = 0;
    int rdy_left = 0;
    int mismatches = 0;

    round_robin_process_scheduler_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // Load segment of a slot: slot + 2 in the top nibble
    function automatic logic [rrps_pkg::SEG_W-1:0] segment_for(rrps_pkg::slot_idx_t s);
        return {4'(s) + 4'd2, 12'h000};
    endfunction

    // Apply one command to the state mirror and return the dispatch it causes
    function automatic dispatch_t dispatch(sched_cmd_t c);
        dispatch_t           r;
        rrps_pkg::slot_idx_t cand;
        rrps_pkg::slot_idx_t pick;
        logic                hit;
        r = '0;
        hit = 1'b0;
        pick = '0;
        case (c.cmd)
            rrps_pkg::CMD_TICK:
            begin
                r.resume_segment = c.cur_segment;
                r.resume_sp      = c.cur_sp;
                if (tick_cnt >= quantum)
                begin
                    tick_cnt = '0;
                    // from idle scan upward from 0, else after current, current last
                    for (int i = 0; i < rrps_pkg::NUM_SLOTS; i++)
                    begin
                        cand = proc_idle ? rrps_pkg::slot_idx_t'(i)
                                         : rrps_pkg::slot_idx_t'(proc_cur
                                               + rrps_pkg::slot_idx_t'(1)
                                               + rrps_pkg::slot_idx_t'(i));
                        if (!hit && proc_live[cand])
                        begin
                            hit  = 1'b1;
                            pick = cand;
                        end
                    end
                    if (hit && (proc_idle || pick != proc_cur))
                    begin
                        if (!proc_idle)
                        begin
                            proc_saved_sp[proc_cur] = c.cur_sp;
                        end
                        proc_cur         = pick;
                        proc_idle        = 1'b0;
                        r.resume_segment = segment_for(pick);
                        r.resume_sp      = proc_saved_sp[pick];
                        r.switched       = 1'b1;
                    end
                end
                else
                begin
                    tick_cnt = tick_cnt + 7'd1;
                end
            end
            rrps_pkg::CMD_FIND_FREE:
            begin
                r.status = rrps_pkg::ST_NO_FREE;
                for (int i = 0; i < rrps_pkg::NUM_SLOTS; i++)
                begin
                    if (!hit && !proc_live[i])
                    begin
                        hit            = 1'b1;
                        r.free_slot    = rrps_pkg::slot_idx_t'(i);
                        r.load_segment = segment_for(rrps_pkg::slot_idx_t'(i));
                        r.status       = rrps_pkg::ST_OK;
                    end
                end
            end
            rrps_pkg::CMD_ACTIVATE:
            begin
                proc_live[c.slot] = 1'b1;
            end
            rrps_pkg::CMD_KILL:
            begin
                proc_live[c.slot]     = 1'b0;
                proc_saved_sp[c.slot] = rrps_pkg::STACK_INIT;
            end
            rrps_pkg::CMD_TERMINATE:
            begin
                // slot stays marked as running until the next switch
                if (proc_idle)
                begin
                    r.status = rrps_pkg::ST_NO_RUN;
                end
                else
                begin
                    proc_live[proc_cur]     = 1'b0;
                    proc_saved_sp[proc_cur] = rrps_pkg::STACK_INIT;
                end
            end
            default:
            begin
            end
        endcase
        r.running      = !proc_idle;
        r.running_slot = proc_idle ? rrps_pkg::slot_idx_t'(0) : proc_cur;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [rrps_pkg::SEG_W-1:0] want,
                                          logic [rrps_pkg::SEG_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ERROR %s: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_cmd(logic [2:0] cmd, logic [rrps_pkg::SEG_W-1:0] seg,
                             logic [rrps_pkg::SEG_W-1:0] sp, rrps_pkg::slot_idx_t slot);
        sched_cmd_t c;
        c.cmd         = cmd;
        c.slot        = slot;
        c.cur_sp      = sp;
        c.cur_segment = seg;
        pending_cmds.push_back(c);
    endtask

    // Mostly ticks, enough activations to fill the table now and then
    task automatic queue_random_cmd();
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 48)
            cmd = rrps_pkg::CMD_TICK;
        else if (r < 66)
            cmd = rrps_pkg::CMD_ACTIVATE;
        else if (r < 76)
            cmd = rrps_pkg::CMD_KILL;
        else if (r < 86)
            cmd = rrps_pkg::CMD_FIND_FREE;
        else if (r < 95)
            cmd = rrps_pkg::CMD_TERMINATE;
        else
            cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        queue_cmd(cmd, rrps_pkg::SEG_W'($urandom), rrps_pkg::SEG_W'($urandom),
                  rrps_pkg::slot_idx_t'($urandom_range(0, rrps_pkg::NUM_SLOTS - 1)));
    endtask

    // Wait until every queued command is through and every result is back
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || dispatch_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_quantum(logic [rrps_pkg::TICK_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        quantum = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

    // Sender: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                dispatch_due.push_back(dispatch(bus_cmd));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    drv_next = pending_cmds.pop_front();
                    bus_cmd  <= drv_next;
                    s_tuser  <= 8'(drv_next.cmd);
                    s_tdata  <= 40'({drv_next.slot, drv_next.cur_sp, drv_next.cur_segment});
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_accepted >= 400)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks results, stalls in modes of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (dispatch_due.size() == 0)
                begin
                    $display("%0t ERROR unexpected result: expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    mon_want = dispatch_due.pop_front();
                    mon_got  = dispatch_t'(m_tdata);
                    compare_field("resume_segment", mon_want.resume_segment,
                                  mon_got.resume_segment);
                    compare_field("resume_sp", mon_want.resume_sp, mon_got.resume_sp);
                    compare_field("switched", 16'(mon_want.switched), 16'(mon_got.switched));
                    compare_field("free_slot", 16'(mon_want.free_slot), 16'(mon_got.free_slot));
                    compare_field("load_segment", mon_want.load_segment,
                                  mon_got.load_segment);
                    compare_field("running", 16'(mon_want.running), 16'(mon_got.running));
                    compare_field("running_slot", 16'(mon_want.running_slot),
                                  16'(mon_got.running_slot));
                    compare_field("status", 16'(mon_want.status), 16'(mon_got.status));
                end
            end
            if (rdy_left == 0)
            begin
                rdy_mode = $urandom_range(0, 2);
                rdy_left = $urandom_range(20, 150);
            end
            else
            begin
                rdy_left--;
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (rdy_mode == 0)
                m_tready <= 1'b1;
            else if (rdy_mode == 1)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Stimulus: directed checks, then random phases at several quantum limits
    initial
    begin
        logic [rrps_pkg::TICK_W-1:0] limit_plan [6];
        proc_live = '0;
        for (int i = 0; i < rrps_pkg::NUM_SLOTS; i++)
            proc_saved_sp[i] = rrps_pkg::STACK_INIT;
        proc_cur  = '0;
        proc_idle = 1'b1;
        tick_cnt  = rrps_pkg::TICK_RESET;
        quantum   = rrps_pkg::QUANTUM_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limit: empty table, idle, spare codes, count up to the limit
        queue_cmd(rrps_pkg::CMD_FIND_FREE, 16'h0000, 16'h0000, 3'd0);
        queue_cmd(rrps_pkg::CMD_TERMINATE, 16'h0000, 16'h0000, 3'd0);
        queue_cmd(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 3'd7);
        queue_cmd(CMD_SPARE_HI, 16'hFFFF, 16'hFFFF, 3'd7);
        queue_cmd(rrps_pkg::CMD_TICK, 16'h0000, 16'h0000, 3'd0);
        queue_cmd(rrps_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 3'd7);
        queue_cmd(rrps_pkg::CMD_TICK, 16'h0000, 16'hFFFF, 3'd0);
        queue_cmd(rrps_pkg::CMD_TICK, 16'hFFFF, 16'h0000, 3'd7);
        queue_cmd(rrps_pkg::CMD_TICK, 16'h8001, 16'h7FFE, 3'd0);
        // counter hits the limit with no slot active: stays idle
        queue_cmd(rrps_pkg::CMD_TICK, 16'h1234, 16'h5678, 3'd0);
        queue_cmd(rrps_pkg::CMD_ACTIVATE, 16'h0000, 16'h0000, 3'd0);
        queue_cmd(rrps_pkg::CMD_ACTIVATE, 16'h0000, 16'h0000, 3'd7);
        queue_cmd(rrps_pkg::CMD_FIND_FREE, 16'h0000, 16'h0000, 3'd0);
        wait_quiet();

        // Limit 0: every tick tries a switch
        write_quantum(7'd0);
        queue_cmd(rrps_pkg::CMD_TICK, 16'hFFFF, 16'h1234, 3'd0);  // leave idle, nothing saved
        queue_cmd(rrps_pkg::CMD_TICK, 16'hAAAA, 16'hABCD, 3'd0);  // step up to slot 7
        queue_cmd(rrps_pkg::CMD_TICK, 16'h5555, 16'h5555, 3'd0);
        queue_cmd(rrps_pkg::CMD_KILL, 16'h0000, 16'h0000, 3'd0);  // kill the running slot
        queue_cmd(rrps_pkg::CMD_TICK, 16'h0001, 16'h0001, 3'd0);
        queue_cmd(rrps_pkg::CMD_TERMINATE, 16'h0000, 16'h0000, 3'd0);
        queue_cmd(rrps_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 3'd0);  // nothing active, keep current
        wait_quiet();

        limit_plan[0] = 7'd1;
        limit_plan[1] = 7'd127;
        limit_plan[2] = 7'd0;
        limit_plan[3] = rrps_pkg::TICK_W'($urandom_range(2, 40));
        limit_plan[4] = rrps_pkg::QUANTUM_RESET;
        limit_plan[5] = rrps_pkg::TICK_W'($urandom_range(1, 10));
        for (int p = 0; p < 6; p++)
        begin
            write_quantum(limit_plan[p]);
            repeat (320) queue_random_cmd();
            wait_quiet();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0 && dispatch_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
